@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the project.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, gated off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/pvd_pkg.sv @@
// Shared types, constants and helper functions of the PVD extractor.
// No dependencies; imported by every RTL module of the block.
package pvd_pkg;

	localparam int QUEUE_BITS = 21;
	localparam int CNT_W      = 5;
	localparam int CHAR_W     = 8;

	// One input pixel
	typedef struct packed {
		logic              first;
		logic [CHAR_W-1:0] red;
		logic [CHAR_W-1:0] green;
		logic [CHAR_W-1:0] blue;
	} pvd_pixel_t;

	// Extraction state carried from pixel to pixel
	typedef struct packed {
		logic [QUEUE_BITS-1:0] queue;
		logic [CNT_W-1:0]      count;
		logic                  finished;
	} pvd_state_t;

	// Characters produced by one pixel; num is 0, 1 or 2
	typedef struct packed {
		logic [1:0]        num;
		logic [CHAR_W-1:0] char0;
		logic [CHAR_W-1:0] char1;
	} pvd_result_t;

	function automatic logic [CHAR_W-1:0] abs_diff(input logic [CHAR_W-1:0] a,
			input logic [CHAR_W-1:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	// Number of embedded bits for a difference, by range
	function automatic logic [2:0] diff_bits(input logic [CHAR_W-1:0] d);
		if (d < 8'd16)
			diff_bits = 3'd3;
		else if (d < 8'd32)
			diff_bits = 3'd4;
		else if (d < 8'd64)
			diff_bits = 3'd5;
		else if (d < 8'd128)
			diff_bits = 3'd6;
		else
			diff_bits = 3'd7;
	endfunction

	function automatic logic [CHAR_W-1:0] low_bits(input logic [CHAR_W-1:0] d,
			input logic [2:0] n);
		low_bits = d & ((8'd1 << n) - 8'd1);
	endfunction

endpackage

@@ rtl/pvd_stego_extractor.sv @@
// Top level of the pixel value differencing message extractor.
// Depends on pvd_pkg, pvd_bit_unit and pvd_out_queue.
//
// Takes one RGB pixel per transaction on s_* and returns the hidden message on m_*,
// one character per transaction, a zero character flagged on tuser as the end of the
// message and tlast on the final character of each pixel. A pixel is taken every cycle
// as long as the output keeps up: each pixel makes zero, one or two characters, and the
// single output port moves one character per cycle unless m_tready is low; a two-entry
// result queue absorbs pixels with two characters and output stalls. An accepted pixel
// passes the input register and a result queue entry before its first character is
// on m_*. After the end of a message, pixels are taken and dropped until one has tuser set.
module pvd_stego_extractor import pvd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	input  logic              s_tuser,   // [0] first_pixel
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] m_tdata,   // [7:0] character
	output logic              m_tuser,   // [0] terminator
	output logic              m_tlast
);

	logic        in_valid_s1;
	pvd_pixel_t  pixel_s1;
	pvd_state_t  state_q, state_nx;
	pvd_result_t result;
	logic        can_push, advance, push;

	// the held pixel moves on once its characters have room
	assign advance  = in_valid_s1 && (result.num == 2'd0 || can_push);
	assign push     = advance && (result.num != 2'd0);
	assign s_tready = !in_valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_tready)
			in_valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pixel_s1.first <= s_tuser;
			pixel_s1.red   <= s_tdata[7:0];
			pixel_s1.green <= s_tdata[15:8];
			pixel_s1.blue  <= s_tdata[23:16];
		end
	end

	// extraction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (advance)
			state_q <= state_nx;
	end

	pvd_bit_unit u_bit (
		.pixel    (pixel_s1),
		.state    (state_q),
		.state_nx (state_nx),
		.result   (result)
	);

	pvd_out_queue u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.can_push  (can_push),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ rtl/pvd_bit_unit.sv @@
// Per-pixel datapath: differences, bit append and character extraction.
// Depends on pvd_pkg; purely combinational, used by pvd_stego_extractor.
module pvd_bit_unit import pvd_pkg::*; (
	input  pvd_pixel_t  pixel,
	input  pvd_state_t  state,
	output pvd_state_t  state_nx,
	output pvd_result_t result
);

	localparam logic [CNT_W-1:0] ONE_CHAR = CNT_W'(CHAR_W);
	localparam logic [CNT_W-1:0] TWO_CHAR = CNT_W'(2 * CHAR_W);

	logic [QUEUE_BITS-1:0] q0, q1, q2;
	logic [CNT_W-1:0]      c0, c2, c_left;
	logic                  fin0;
	logic [CHAR_W-1:0]     d1, d2;
	logic [2:0]            n1, n2;
	logic [CHAR_W-1:0]     char0, char1;
	logic [1:0]            num;
	logic                  term;

	// first pixel clears the state before the pixel is used
	assign q0   = pixel.first ? '0 : state.queue;
	assign c0   = pixel.first ? '0 : state.count;
	assign fin0 = pixel.first ? 1'b0 : state.finished;

	// differences and their bit counts
	assign d1 = abs_diff(pixel.red, pixel.green);
	assign d2 = abs_diff(pixel.green, pixel.blue);
	assign n1 = diff_bits(d1);
	assign n2 = diff_bits(d2);

	// append both groups, oldest bits on top
	assign q1 = (q0 << n1) | QUEUE_BITS'(low_bits(d1, n1));
	assign q2 = (q1 << n2) | QUEUE_BITS'(low_bits(d2, n2));
	assign c2 = c0 + CNT_W'(n1) + CNT_W'(n2);

	// up to two characters, most significant first
	assign char0 = (c2 >= ONE_CHAR) ? CHAR_W'(q2 >> (c2 - ONE_CHAR)) : '0;
	assign char1 = (c2 >= TWO_CHAR) ? CHAR_W'(q2 >> (c2 - TWO_CHAR)) : '0;

	always_comb begin
		if (fin0)
			num = 2'd0;
		else if (c2 >= TWO_CHAR && char0 != '0)
			num = 2'd2;
		else if (c2 >= ONE_CHAR)
			num = 2'd1;
		else
			num = 2'd0;
	end

	// a zero character ends the message
	assign term = (num != 2'd0 && char0 == '0) || (num == 2'd2 && char1 == '0);
	assign c_left = c2 - CNT_W'({num, 3'b000});

	always_comb begin
		if (fin0) begin
			state_nx = state;
		end else begin
			state_nx.queue    = q2 & ~({QUEUE_BITS{1'b1}} << c_left);
			state_nx.count    = c_left;
			state_nx.finished = term;
		end
	end

	assign result.num   = num;
	assign result.char0 = char0;
	assign result.char1 = char1;

endmodule

@@ rtl/pvd_out_queue.sv @@
// Two-entry result queue that hands characters to the output stream one at a time.
// Depends on pvd_pkg; used by pvd_stego_extractor.
module pvd_out_queue import pvd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pvd_result_t       push_data,
	output logic              can_push,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] m_tdata,   // [7:0] character
	output logic              m_tuser,   // [0] terminator
	output logic              m_tlast
);

	pvd_result_t entries_q [2];
	logic        wr_ptr_q, rd_ptr_q, sub_q;
	logic [1:0]  cnt_q;
	pvd_result_t head;
	logic        pop_item, pop_entry;

	assign head      = entries_q[rd_ptr_q];
	assign can_push  = (cnt_q != 2'd2);
	assign m_tvalid  = (cnt_q != 2'd0);
	assign m_tdata   = sub_q ? head.char1 : head.char0;
	assign m_tlast   = (head.num == 2'd1) || sub_q;
	assign m_tuser   = (m_tdata == '0);
	assign pop_item  = m_tvalid && m_tready;
	assign pop_entry = pop_item && m_tlast;

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_data;
	end

	// pointers, fill count and character index within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			sub_q    <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop_entry)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop_entry);
			if (pop_entry)
				sub_q <= 1'b0;
			else if (pop_item)
				sub_q <= 1'b1;
		end
	end

endmodule

@@ rtl/pvd_checker.sv @@
// Port-level checks of the PVD extractor's output stream, bound to the top level.
// Depends on assert_macros.svh and pvd_stego_extractor.
`include "assert_macros.svh"

module pvd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// stalled transaction holds
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ASSERT_NEXT(a_hold_flags, clk, arst_n, m_tvalid && !m_tready, $stable(m_tuser) && $stable(m_tlast))
	// end of message is always the final character of its pixel
	`ASSERT_IMPLY(a_term_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	// terminator flag matches a zero character
	`ASSERT_IMPLY(a_term_zero, clk, arst_n, m_tvalid, (m_tdata == 8'd0) == m_tuser)

endmodule

bind pvd_stego_extractor pvd_checker u_pvd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
